// ===== src/wsd_pkg.sv =====
// ----------------------------------------------------------------------------
// WebSocket deframer package
// Shared types and constants for the frame header parser and its result path.
// ----------------------------------------------------------------------------
package wsd_pkg;

    localparam int unsigned LEN_W = 63;

    // Register defaults after reset.
    localparam logic             REQUIRE_MASK_RST = 1'b1;
    localparam logic [LEN_W-1:0] MAX_LEN_RST      = LEN_W'(10 * 1024 * 1024);

    // Seven-bit length codes that announce an extended length.
    localparam logic [6:0] LEN_CODE_16 = 7'd126;
    localparam logic [6:0] LEN_CODE_64 = 7'd127;

    // Opcodes that are accepted.
    localparam logic [3:0] OP_CONT   = 4'h0;
    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE  = 4'h8;
    localparam logic [3:0] OP_PING   = 4'h9;
    localparam logic [3:0] OP_PONG   = 4'hA;

    // Configuration register indexes (byte address bit 3).
    localparam logic REG_REQUIRE_MASK = 1'b0;
    localparam logic REG_MAX_LEN      = 1'b1;

    typedef enum logic [2:0] {
        EV_PAYLOAD   = 3'd0,
        EV_EMPTY     = 3'd1,
        EV_BAD_OP    = 3'd2,
        EV_UNMASKED  = 3'd3,
        EV_TOO_LONG  = 3'd4
    } t_event;

    typedef struct packed {
        logic             require_mask;
        logic [LEN_W-1:0] max_len;
    } t_cfg;

    typedef struct packed {
        t_event           kind;
        logic [7:0]       payload;
        logic [3:0]       opcode;
        logic             fin;
        logic [LEN_W-1:0] length;
        logic             last;
    } t_result;

endpackage

// ===== src/websocket_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// WebSocket frame deframer
// Parses received frame headers byte by byte and returns unmasked payload.
// ----------------------------------------------------------------------------
//  Channel   Direction  Carries
//  s_*       in         received byte, tdata[7:0]; restart flag, tuser[0]
//  m_*       out        payload/event request; kind in tuser, last in tlast
//  APB       in/out     require_mask at 0x0, max_frame_length at 0x8
//
// One byte is accepted per cycle; a byte taken goes into the input register,
// and its result reaches m_* through the result register.
// Throughput is one byte per cycle while m_tready stays high; a stall on the
// result side holds the input register and drops s_tready only when both
// registers are full. Synchronous reset clears parser state and valid flags.
// ----------------------------------------------------------------------------
module websocket_frame_deframer
    import wsd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] restart
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // [7:0] payload_byte, [11:8] frame_opcode,
                                   // [12] final_fragment, [75:13] frame_length
    output logic [2:0]  m_tuser,   // [2:0] event_kind
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    t_cfg    cfg;
    logic    res_valid;
    logic    res_ready;
    t_result res;

    wsd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    wsd_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_in_valid   (s_tvalid),
        .o_in_ready   (s_tready),
        .i_in_byte    (s_tdata),
        .i_in_restart (s_tuser),
        .i_res_ready  (res_ready),
        .o_res_valid  (res_valid),
        .o_res        (res)
    );

    wsd_obuf u_obuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_res_ready (res_ready),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule

// ===== src/wsd_cfg.sv =====
// ----------------------------------------------------------------------------
// WebSocket deframer configuration registers
// Register file behind the peripheral bus port: mask policy and length limit.
// ----------------------------------------------------------------------------
module wsd_cfg
    import wsd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    logic             r_require_mask;
    logic [LEN_W-1:0] r_max_len;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // Registers are decoded on address bit 3 alone, eight bytes apart.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_require_mask <= REQUIRE_MASK_RST;
            r_max_len      <= MAX_LEN_RST;
        end else if (wr_en) begin
            unique case (paddr[3])
                REG_REQUIRE_MASK: r_require_mask <= pwdata[0];
                REG_MAX_LEN:      r_max_len      <= pwdata[LEN_W-1:0];
                default:          r_max_len      <= r_max_len;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3])
            REG_REQUIRE_MASK: prdata = {63'd0, r_require_mask};
            REG_MAX_LEN:      prdata = {1'b0, r_max_len};
            default:          prdata = '0;
        endcase
    end

    assign o_cfg.require_mask = r_require_mask;
    assign o_cfg.max_len      = r_max_len;

endmodule

// ===== src/wsd_parser.sv =====
// ----------------------------------------------------------------------------
// WebSocket deframer header parser
// Input register, header state and unmasking: one byte a cycle unless stalled.
// ----------------------------------------------------------------------------
module wsd_parser
    import wsd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_restart,
    input  logic       i_res_ready,
    output logic       o_res_valid,
    output t_result    o_res
);

    typedef enum logic [2:0] {
        PH_START   = 3'd0,
        PH_SECOND  = 3'd1,
        PH_EXTLEN  = 3'd2,
        PH_KEY     = 3'd3,
        PH_PAYLOAD = 3'd4
    } t_phase;

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_restart;

    t_phase      r_phase,  n_phase,  c_phase;
    logic [3:0]  r_hbc,    n_hbc,    c_hbc;
    logic        r_fin,    n_fin,    c_fin;
    logic [3:0]  r_op,     n_op,     c_op;
    logic        r_mask,   n_mask,   c_mask;
    logic [63:0] r_len,    n_len,    c_len;
    logic [31:0] r_key,    n_key,    c_key;
    logic [63:0] r_rem,    n_rem,    c_rem;
    logic [1:0]  r_kidx,   n_kidx,   c_kidx;
    logic        r_err,    n_err,    c_err;

    logic        advance;
    logic        do_lk;
    logic        do_bp;
    logic        op_ok;
    logic [7:0]  key_byte;
    logic        res_valid;
    t_result     res;

    // The parser moves on a held byte whenever the result stage can take a request.
    assign advance    = i_res_ready;
    assign o_in_ready = !r_in_valid || advance;

    always_comb begin
        // A restart clears everything before the byte is looked at.
        if (r_in_restart) begin
            c_phase = PH_START;
            c_hbc   = '0;
            c_fin   = 1'b0;
            c_op    = '0;
            c_mask  = 1'b0;
            c_len   = '0;
            c_key   = '0;
            c_rem   = '0;
            c_kidx  = '0;
            c_err   = 1'b0;
        end else begin
            c_phase = r_phase;
            c_hbc   = r_hbc;
            c_fin   = r_fin;
            c_op    = r_op;
            c_mask  = r_mask;
            c_len   = r_len;
            c_key   = r_key;
            c_rem   = r_rem;
            c_kidx  = r_kidx;
            c_err   = r_err;
        end

        n_phase = c_phase;
        n_hbc   = c_hbc;
        n_fin   = c_fin;
        n_op    = c_op;
        n_mask  = c_mask;
        n_len   = c_len;
        n_key   = c_key;
        n_rem   = c_rem;
        n_kidx  = c_kidx;
        n_err   = c_err;

        do_lk     = 1'b0;
        do_bp     = 1'b0;
        res_valid = 1'b0;
        res.kind    = EV_PAYLOAD;
        res.payload = '0;
        res.length  = '0;
        res.last    = 1'b0;

        op_ok = (r_in_byte[3:0] == OP_CONT) || (r_in_byte[3:0] == OP_TEXT) ||
                (r_in_byte[3:0] == OP_BINARY) || (r_in_byte[3:0] == OP_CLOSE) ||
                (r_in_byte[3:0] == OP_PING) || (r_in_byte[3:0] == OP_PONG);

        unique case (c_kidx)
            2'd0:    key_byte = c_key[31:24];
            2'd1:    key_byte = c_key[23:16];
            2'd2:    key_byte = c_key[15:8];
            default: key_byte = c_key[7:0];
        endcase

        if (!c_err) begin
            unique case (c_phase)
                PH_START: begin
                    n_fin  = r_in_byte[7];
                    n_op   = r_in_byte[3:0];
                    n_mask = 1'b0;
                    n_len  = '0;
                    n_key  = '0;
                    n_kidx = '0;
                    n_rem  = '0;
                    if (!op_ok) begin
                        n_err     = 1'b1;
                        res_valid = 1'b1;
                        res.kind  = EV_BAD_OP;
                    end else begin
                        n_phase = PH_SECOND;
                    end
                end
                PH_SECOND: begin
                    n_mask = r_in_byte[7];
                    if (i_cfg.require_mask && !r_in_byte[7]) begin
                        n_err     = 1'b1;
                        n_phase   = PH_START;
                        res_valid = 1'b1;
                        res.kind  = EV_UNMASKED;
                    end else if (r_in_byte[6:0] == LEN_CODE_16) begin
                        n_hbc   = 4'd2;
                        n_len   = '0;
                        n_phase = PH_EXTLEN;
                    end else if (r_in_byte[6:0] == LEN_CODE_64) begin
                        n_hbc   = 4'd8;
                        n_len   = '0;
                        n_phase = PH_EXTLEN;
                    end else begin
                        n_len = {57'd0, r_in_byte[6:0]};
                        do_lk = 1'b1;
                    end
                end
                PH_EXTLEN: begin
                    n_len = {c_len[55:0], r_in_byte};
                    n_hbc = c_hbc - 4'd1;
                    do_lk = (n_hbc == 4'd0);
                end
                PH_KEY: begin
                    n_key = {c_key[23:0], r_in_byte};
                    n_hbc = c_hbc - 4'd1;
                    do_bp = (n_hbc == 4'd0);
                end
                PH_PAYLOAD: begin
                    n_kidx      = c_kidx + 2'd1;
                    n_rem       = c_rem - 64'd1;
                    res_valid   = 1'b1;
                    res.kind    = EV_PAYLOAD;
                    res.payload = r_in_byte ^ key_byte;
                    res.length  = c_len[LEN_W-1:0];
                    res.last    = (n_rem == 64'd0);
                    if (n_rem == 64'd0) begin
                        n_phase = PH_START;
                    end
                end
                default: n_phase = PH_START;
            endcase
        end

        // Whole length known: check the limit, then key or payload.
        if (do_lk) begin
            if (n_len > {1'b0, i_cfg.max_len}) begin
                n_err      = 1'b1;
                n_phase    = PH_START;
                res_valid  = 1'b1;
                res.kind   = EV_TOO_LONG;
                res.length = n_len[LEN_W-1:0];
            end else if (n_mask) begin
                n_hbc   = 4'd4;
                n_phase = PH_KEY;
            end else begin
                do_bp = 1'b1;
            end
        end

        if (do_bp) begin
            n_kidx = '0;
            n_rem  = n_len;
            if (n_len == 64'd0) begin
                n_phase   = PH_START;
                res_valid = 1'b1;
                res.kind  = EV_EMPTY;
                res.last  = 1'b1;
            end else begin
                n_phase = PH_PAYLOAD;
            end
        end

        res.opcode = n_op;
        res.fin    = n_fin;
        res_valid  = res_valid && r_in_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_phase    <= PH_START;
            r_hbc      <= '0;
            r_fin      <= 1'b0;
            r_op       <= '0;
            r_mask     <= 1'b0;
            r_len      <= '0;
            r_key      <= '0;
            r_rem      <= '0;
            r_kidx     <= '0;
            r_err      <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
                if (i_in_valid) begin
                    r_in_byte    <= i_in_byte;
                    r_in_restart <= i_in_restart;
                end
            end
            if (r_in_valid && advance) begin
                r_phase <= n_phase;
                r_hbc   <= n_hbc;
                r_fin   <= n_fin;
                r_op    <= n_op;
                r_mask  <= n_mask;
                r_len   <= n_len;
                r_key   <= n_key;
                r_rem   <= n_rem;
                r_kidx  <= n_kidx;
                r_err   <= n_err;
            end
        end
    end

    assign o_res_valid = res_valid;
    assign o_res       = res;

`ifndef SYNTHESIS
    a_err_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_err && !r_in_restart |-> !res_valid)
        else $error("result produced while an error is latched");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=>
            r_in_valid && $stable(r_in_byte) && $stable(r_in_restart))
        else $error("input request changed while the result stage was full");

    a_payload_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_PAYLOAD |-> r_rem != 64'd0)
        else $error("payload phase with no bytes remaining");

    a_last_ends_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid && res.last && advance |=> r_phase == PH_START)
        else $error("frame end did not return to frame start");
`endif

endmodule

// ===== src/wsd_obuf.sv =====
// ----------------------------------------------------------------------------
// WebSocket deframer result register
// Holds one result request for the downstream side and packs it for the bus.
// ----------------------------------------------------------------------------
module wsd_obuf
    import wsd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_res_valid,
    input  t_result     i_res,
    output logic        o_res_ready,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,
    output logic [2:0]  m_tuser,
    output logic        m_tlast
);

    logic    r_valid;
    t_result r_res;

    assign o_res_ready = !r_valid || m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            if (o_res_ready) begin
                r_valid <= i_res_valid;
                if (i_res_valid) begin
                    r_res <= i_res;
                end
            end
        end
    end

    assign m_tvalid = r_valid;
    assign m_tdata  = {4'd0, r_res.length, r_res.fin, r_res.opcode, r_res.payload};
    assign m_tuser  = r_res.kind;
    assign m_tlast  = r_res.last;

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// WebSocket frame deframer testbench
// Sends well-formed frames with random content and random header encodings.
// Error frames, truncated frames and noise are mixed in. A byte-level
// parser model predicts every event request, and the monitor checks each
// result field by field. Both stream sides stall at random.
// ----------------------------------------------------------------------------
module tb;
    import wsd_pkg::*;

    // Opcode outside the accepted set, for the directed part.
    localparam logic [3:0] OP_BAD = 4'hB;

    typedef enum logic [2:0] {
        PS_START,
        PS_SECOND,
        PS_EXTLEN,
        PS_KEY,
        PS_PAYLOAD
    } t_parse_state;

    typedef struct {
        logic [7:0] data;
        logic       restart;
    } t_rx_byte;

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;    // [7:0] data_byte
    logic        s_tuser  = 1'b0;     // [0] restart
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;             // [7:0] payload_byte, [11:8] frame_opcode,
                                      // [12] final_fragment, [75:13] frame_length
    logic [2:0]  m_tuser;             // [2:0] event_kind
    logic        m_tlast;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [3:0]  paddr    = 4'h0;
    logic [63:0] pwdata   = 64'h0;
    logic [63:0] prdata;
    logic        pready;

    t_rx_byte rx_bytes[$];
    t_rx_byte next_byte;
    t_result  due_events[$];
    int       mismatches = 0;
    int       bytes_taken = 0;
    int       stim_count = 0;
    logic     want_restart = 1'b0;
    logic     steady;

    // Configuration copy and parser state of the model.
    logic             cfg_need_mask = REQUIRE_MASK_RST;
    logic [LEN_W-1:0] cfg_len_limit = MAX_LEN_RST;
    t_parse_state     st_phase;
    logic [3:0]       hdr_left;
    logic             cur_fin;
    logic [3:0]       cur_op;
    logic             has_mask;
    logic [63:0]      cur_len;
    logic [31:0]      cur_key;
    logic [63:0]      left_bytes;
    logic [1:0]       key_pos;
    logic             err_held;

    logic             phase_need[4]  = '{1'b0, 1'b1, 1'b0, 1'b1};
    logic [63:0]      phase_limit[4] = '{64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 64'd20, 64'd300};

    websocket_frame_deframer DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #4 i_clk = ~i_clk;

    // Neither side idles for a stretch in the middle of the run.
    assign steady = (bytes_taken >= 300) && (bytes_taken < 450);

    function automatic logic opcode_known(input logic [3:0] op);
        return op == OP_CONT || op == OP_TEXT || op == OP_BINARY ||
               op == OP_CLOSE || op == OP_PING || op == OP_PONG;
    endfunction

    task automatic report(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // ------------------------------------------------------------------------
    // Parser model
    // ------------------------------------------------------------------------
    task automatic restart_parser();
        st_phase   = PS_START;
        hdr_left   = 4'd0;
        cur_fin    = 1'b0;
        cur_op     = 4'd0;
        has_mask   = 1'b0;
        cur_len    = 64'd0;
        cur_key    = 32'd0;
        left_bytes = 64'd0;
        key_pos    = 2'd0;
        err_held   = 1'b0;
    endtask

    task automatic push_event(input t_event kind, input logic [7:0] pb,
                              input logic [63:0] len, input logic last);
        t_result ev;
        ev.kind    = kind;
        ev.payload = pb;
        ev.opcode  = cur_op;
        ev.fin     = cur_fin;
        ev.length  = len[LEN_W-1:0];
        ev.last    = last;
        due_events = {due_events, ev};
    endtask

    task automatic latch_error(input t_event kind, input logic [63:0] len);
        err_held = 1'b1;
        st_phase = PS_START;
        push_event(kind, 8'h00, len, 1'b0);
    endtask

    task automatic open_payload();
        key_pos    = 2'd0;
        left_bytes = cur_len;
        if (cur_len == 64'd0) begin
            st_phase = PS_START;
            push_event(EV_EMPTY, 8'h00, 64'd0, 1'b1);
        end else begin
            st_phase = PS_PAYLOAD;
        end
    endtask

    task automatic header_length_done();
        if (cur_len > {1'b0, cfg_len_limit}) begin
            latch_error(EV_TOO_LONG, cur_len);
        end else if (has_mask) begin
            hdr_left = 4'd4;
            st_phase = PS_KEY;
        end else begin
            open_payload();
        end
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic restart);
        logic [7:0] kb;
        logic       last;
        if (restart)
            restart_parser();
        if (err_held)
            return;
        case (st_phase)
            PS_START: begin
                cur_fin    = b[7];
                cur_op     = b[3:0];
                has_mask   = 1'b0;
                cur_len    = 64'd0;
                cur_key    = 32'd0;
                key_pos    = 2'd0;
                left_bytes = 64'd0;
                if (!opcode_known(cur_op))
                    latch_error(EV_BAD_OP, 64'd0);
                else
                    st_phase = PS_SECOND;
            end
            PS_SECOND: begin
                has_mask = b[7];
                if (cfg_need_mask && !has_mask) begin
                    latch_error(EV_UNMASKED, 64'd0);
                end else if (b[6:0] == LEN_CODE_16 || b[6:0] == LEN_CODE_64) begin
                    hdr_left = (b[6:0] == LEN_CODE_16) ? 4'd2 : 4'd8;
                    cur_len  = 64'd0;
                    st_phase = PS_EXTLEN;
                end else begin
                    cur_len = {57'd0, b[6:0]};
                    header_length_done();
                end
            end
            PS_EXTLEN: begin
                cur_len  = {cur_len[55:0], b};
                hdr_left = hdr_left - 4'd1;
                if (hdr_left == 4'd0)
                    header_length_done();
            end
            PS_KEY: begin
                cur_key  = {cur_key[23:0], b};
                hdr_left = hdr_left - 4'd1;
                if (hdr_left == 4'd0)
                    open_payload();
            end
            PS_PAYLOAD: begin
                // The first key byte sits in the top bits of the key.
                kb         = cur_key[8 * (3 - key_pos) +: 8];
                key_pos    = key_pos + 2'd1;
                left_bytes = left_bytes - 64'd1;
                last       = (left_bytes == 64'd0);
                if (last)
                    st_phase = PS_START;
                push_event(EV_PAYLOAD, b ^ kb, cur_len, last);
            end
            default: begin
                st_phase = PS_START;
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    task automatic queue_byte(input logic [7:0] b, input logic restart);
        t_rx_byte rb;
        rb.data    = b;
        rb.restart = restart;
        rx_bytes = {rx_bytes, rb};
        stim_count++;
    endtask

    // Bytes sent while the error is latched; they are not counted.
    task automatic queue_ignored();
        int n;
        t_rx_byte rb;
        n = $urandom_range(0, 3);
        repeat (n) begin
            rb.data    = 8'($urandom);
            rb.restart = 1'b0;
            rx_bytes = {rx_bytes, rb};
        end
    endtask

    // Second header byte and extended length, in a randomly chosen form.
    task automatic queue_length(input logic mbit, input logic [63:0] flen);
        int i;
        if (flen < 64'd126 && $urandom_range(0, 3) != 0) begin
            queue_byte({mbit, flen[6:0]}, 1'b0);
        end else if (flen < 64'd65536 && $urandom_range(0, 1) == 1) begin
            queue_byte({mbit, LEN_CODE_16}, 1'b0);
            queue_byte(flen[15:8], 1'b0);
            queue_byte(flen[7:0], 1'b0);
        end else begin
            queue_byte({mbit, LEN_CODE_64}, 1'b0);
            for (i = 7; i >= 0; i--)
                queue_byte(flen[8 * i +: 8], 1'b0);
        end
    endtask

    task automatic queue_frame();
        int          pick;
        int          sel;
        int          plen;
        int          i;
        logic [63:0] flen;
        logic [3:0]  op;
        logic        mbit;
        logic        first_restart;
        logic [31:0] mkey;
        pick = $urandom_range(0, 99);
        first_restart = want_restart || ($urandom_range(0, 9) == 0);
        want_restart = 1'b0;
        if (pick < 8) begin
            do op = 4'($urandom_range(0, 15)); while (opcode_known(op));
            queue_byte({1'($urandom), 3'($urandom), op}, first_restart);
            queue_ignored();
            want_restart = 1'b1;
            return;
        end
        if (pick < 13) begin
            sel = $urandom_range(1, 6);
            for (i = 0; i < sel; i++)
                queue_byte(8'($urandom), $urandom_range(0, 3) == 0);
            want_restart = 1'b1;
            return;
        end
        case ($urandom_range(0, 5))
            0:       op = OP_CONT;
            1:       op = OP_TEXT;
            2:       op = OP_BINARY;
            3:       op = OP_CLOSE;
            4:       op = OP_PING;
            default: op = OP_PONG;
        endcase
        if (pick >= 88 && pick < 94)
            mbit = 1'b0;
        else if (cfg_need_mask)
            mbit = 1'b1;
        else
            mbit = 1'($urandom);
        sel = $urandom_range(0, 19);
        if (pick >= 94) begin
            if (cfg_len_limit == '1 || $urandom_range(0, 1) == 1)
                flen = {1'b1, 31'($urandom), 32'($urandom)};
            else
                flen = {1'b0, cfg_len_limit} + 64'($urandom_range(1, 4));
        end else if (sel == 0) begin
            flen = 64'($urandom_range(100, 125));
        end else if (sel == 1) begin
            flen = 64'($urandom_range(1000, 100000));
        end else if (sel == 2) begin
            flen = 64'd0;
        end else begin
            flen = 64'($urandom_range(1, 12));
        end
        queue_byte({1'($urandom), 3'($urandom), op}, first_restart);
        if (cfg_need_mask && !mbit) begin
            queue_byte({1'b0, 7'($urandom)}, 1'b0);
            queue_ignored();
            want_restart = 1'b1;
            return;
        end
        queue_length(mbit, flen);
        if (flen > {1'b0, cfg_len_limit}) begin
            queue_ignored();
            want_restart = 1'b1;
            return;
        end
        if (mbit) begin
            mkey = ($urandom_range(0, 7) == 0) ? 32'd0 : 32'($urandom);
            for (i = 3; i >= 0; i--)
                queue_byte(mkey[8 * i +: 8], 1'b0);
        end
        plen = int'(flen);
        // Long announced lengths are always cut short; the next frame restarts.
        if (sel == 1) begin
            plen = $urandom_range(1, 8);
            want_restart = 1'b1;
        end else if (plen > 1 && $urandom_range(0, 19) == 0) begin
            plen = $urandom_range(1, plen - 1);
            want_restart = 1'b1;
        end
        for (i = 0; i < plen; i++)
            queue_byte(8'($urandom), 1'b0);
    endtask

    task automatic queue_directed();
        // Masked text frame with two payload bytes.
        queue_byte({1'b1, 3'b000, OP_TEXT}, 1'b0);
        queue_byte({1'b1, 7'd2}, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hA5, 1'b0);
        queue_byte(8'h5A, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b0);
        // Unknown opcode, then a byte that the latched error swallows.
        queue_byte({1'b0, 3'b000, OP_BAD}, 1'b0);
        queue_byte(8'hFF, 1'b0);
        // Pong with reserved bits set but no mask bit.
        queue_byte({1'b1, 3'b111, OP_PONG}, 1'b1);
        queue_byte({1'b0, 7'd125}, 1'b0);
        // Close with a 64-bit length whose top bit is set.
        queue_byte({1'b0, 3'b000, OP_CLOSE}, 1'b1);
        queue_byte({1'b1, LEN_CODE_64}, 1'b0);
        queue_byte(8'h80, 1'b0);
        repeat (7) queue_byte(8'h00, 1'b0);
        // Masked continuation frame of length zero.
        queue_byte({1'b0, 3'b000, OP_CONT}, 1'b1);
        queue_byte({1'b1, 7'd0}, 1'b0);
        queue_byte(8'h12, 1'b0);
        queue_byte(8'h34, 1'b0);
        queue_byte(8'h56, 1'b0);
        queue_byte(8'h78, 1'b0);
    endtask

    task automatic write_reg(input logic idx, input logic [63:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_REQUIRE_MASK)
            cfg_need_mask = value[0];
        else
            cfg_len_limit = value[LEN_W-1:0];
    endtask

    // Waits until every request is sent and every event has come back.
    task automatic settle();
        while (rx_bytes.size() != 0 || s_tvalid || due_events.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Driver, sink and monitor
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (rx_bytes.size() != 0 && (steady || $urandom_range(0, 99) >= 14)) begin
                next_byte = rx_bytes.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= next_byte.data;
                s_tuser  <= next_byte.restart;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= steady || ($urandom_range(0, 99) >= 14);
    end

    task automatic check_event();
        t_result want;
        if (due_events.size() == 0) begin
            report($sformatf("unexpected event kind %0d", m_tuser));
            return;
        end
        want = due_events.pop_front();
        if (m_tuser !== want.kind)
            report($sformatf("event kind %0d, want %0d", m_tuser, want.kind));
        if (m_tdata[7:0] !== want.payload)
            report($sformatf("payload %02h, want %02h", m_tdata[7:0], want.payload));
        if (m_tdata[11:8] !== want.opcode)
            report($sformatf("opcode %0h, want %0h", m_tdata[11:8], want.opcode));
        if (m_tdata[12] !== want.fin)
            report($sformatf("fin %0b, want %0b", m_tdata[12], want.fin));
        if (m_tdata[75:13] !== want.length)
            report($sformatf("length %0d, want %0d", m_tdata[75:13], want.length));
        if (m_tlast !== want.last)
            report($sformatf("last %0b, want %0b", m_tlast, want.last));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_tvalid && s_tready) begin
                parse_byte(s_tdata, s_tuser);
                bytes_taken++;
            end
            if (m_tvalid && m_tready)
                check_event();
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        int p;
        restart_parser();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        queue_directed();
        while (stim_count < 170)
            queue_frame();
        settle();
        for (p = 0; p < 4; p++) begin
            write_reg(REG_REQUIRE_MASK, {63'd0, phase_need[p]});
            write_reg(REG_MAX_LEN, phase_limit[p]);
            want_restart = 1'b1;
            stim_count = 0;
            while (stim_count < 135)
                queue_frame();
            settle();
        end
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #1_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
